// File: design/pfdl_pkg.sv
// shared types and constants for the pan-driven fractional delay line
package pfdl_pkg;

	localparam int BUFFER_DEPTH_DEF = 2048;

	localparam int SMP_W   = 24;
	localparam int PAN_W   = 16;
	localparam int DLY_W   = 28;
	localparam int FRAC_W  = 16;
	localparam int TGT_W   = 12;
	localparam int FULL_W  = 12;
	localparam int STEP_W  = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_PAN    = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_FULL_DELAY  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERP_STEP = 4'd1;

	// one sample beat on its way from the store read to the output
	typedef struct packed {
		logic signed [SMP_W-1:0] smp;
		logic                    use_in;
		logic                    a_ok;
		logic                    b_ok;
		logic [FRAC_W-1:0]       frac;
		logic [DLY_W-1:0]        delay;
		logic                    ramping;
	} pfdl_item_t;

endpackage

// File: design/pan_fractional_delay_line.sv
// top level of the pan-driven fractional delay line
//
// Input beats carry op, sample_in and pan_pos; a beat is taken at a rising
// edge with in_valid high and in_stall low. A pan beat (op high) updates the
// target delay and returns nothing. A sample beat returns one result beat on
// the output channel with sample_out, delay_now and ramping, in input order.
// One beat is taken per cycle while in_stall is low: the delay state lives
// in flops and the sample store is a ram with two read ports, so both
// neighbouring samples of a fractional delay come in the same cycle. A
// sample result is read from the ram on the edge that takes its beat, then
// multiplied into a second register and rounded into the output register.
// When out_stall is high the output register holds its beat and the two
// stages behind it keep filling; in_stall rises once they are full.
// Configuration writes on cfg_valid/cfg_data/cfg_index are always ready; the
// user makes them only while the block is idle, the block does not enforce it.
// Reset clears all control state, sets full_delay to 0 and interp_step to 655
// and empties the store logically: a wrap flag and the write index mark which
// entries hold samples, unwritten entries read as zero, so no clearing sweep
// is needed and beats are taken from the first cycle after reset.
module pan_fractional_delay_line #(
	parameter int BUFFER_DEPTH = pfdl_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 op,
	input  logic signed [pfdl_pkg::SMP_W-1:0]    sample_in,
	input  logic [pfdl_pkg::PAN_W-1:0]           pan_pos,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [pfdl_pkg::SMP_W-1:0]    sample_out,
	output logic [pfdl_pkg::DLY_W-1:0]           delay_now,
	output logic                                 ramping,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pfdl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pfdl_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import pfdl_pkg::*;

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int BW = (AW > TGT_W) ? AW : TGT_W;
	localparam logic [16:0] DEPTH_V = 17'(BUFFER_DEPTH);

	logic [AW-1:0]     wr_idx_q;
	logic              wrapped_q;
	logic [DLY_W-1:0]  cur_q;
	logic [TGT_W-1:0]  tgt_q;
	logic              ramp_q;
	logic              seen_q;
	logic [FULL_W-1:0] full_delay_q;
	logic [STEP_W-1:0] interp_step_q;

	logic              accept;
	logic              acc_smp;
	logic              acc_pan;
	logic              hold;

	logic [DLY_W-1:0]  tgt_fix;
	logic [DLY_W:0]    cur_x;
	logic [DLY_W:0]    tgt_x;
	logic [DLY_W:0]    step_x;
	logic [DLY_W:0]    up_sum;
	logic              ge;
	logic              dn_done;
	logic              up_done;
	logic [DLY_W-1:0]  cur_rd;
	logic [DLY_W-1:0]  cur_nx;
	logic              ramp_nx;
	logic [TGT_W-1:0]  ip;
	logic [TGT_W-1:0]  dsel;
	logic [BW-1:0]     dsel_x;
	logic [AW-1:0]     rp;
	logic [AW-1:0]     fp;
	logic              bypass;
	logic              we;
	pfdl_item_t        item;

	logic [PAN_W-1:0]  pan_d;
	logic [DLY_W-1:0]  pan_prod;
	logic [TGT_W:0]    nd;
	logic [14:0]       nd_rem;
	logic              nd_up;
	logic [TGT_W:0]    nd_r;
	logic [TGT_W:0]    nd_p;
	logic [TGT_W-1:0]  nd_c;

	logic [SMP_W-1:0]  rd_a;
	logic [SMP_W-1:0]  rd_b;

	assign in_stall  = hold;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign acc_smp   = accept && (op == OP_SAMPLE);
	assign acc_pan   = accept && (op == OP_PAN);

	// ramp arithmetic on the current delay
	always_comb begin
		tgt_fix = {tgt_q, {FRAC_W{1'b0}}};
		cur_x   = {1'b0, cur_q};
		tgt_x   = {1'b0, tgt_fix};
		step_x  = (DLY_W+1)'(interp_step_q);
		ge      = cur_q >= tgt_fix;
		dn_done = cur_x <= (tgt_x + step_x);
		up_sum  = cur_x + step_x;
		up_done = up_sum >= tgt_x;
		if (ramp_q && ge) begin
			cur_rd = dn_done ? tgt_fix : (cur_q - DLY_W'(interp_step_q));
		end else begin
			cur_rd = cur_q;
		end
		if (ge) begin
			cur_nx  = cur_rd;
			ramp_nx = !dn_done;
		end else begin
			cur_nx  = up_done ? tgt_fix : up_sum[DLY_W-1:0];
			ramp_nx = !up_done;
		end
		ip     = cur_rd[DLY_W-1:FRAC_W];
		dsel   = ramp_q ? ip : tgt_q;
		dsel_x = BW'(dsel);
		rp     = wr_idx_q - dsel_x[AW-1:0];
		fp     = rp - AW'(1);
		bypass = !ramp_q && (tgt_q == '0);
		we     = acc_smp && !bypass;
	end

	always_comb begin
		item.smp     = sample_in;
		item.use_in  = ramp_q ? (ip == '0) : (tgt_q == '0);
		item.a_ok    = wrapped_q || (rp < wr_idx_q);
		item.b_ok    = wrapped_q || (fp < wr_idx_q);
		item.frac    = ramp_q ? cur_rd[FRAC_W-1:0] : '0;
		item.delay   = ramp_q ? cur_nx : cur_q;
		item.ramping = ramp_q && ramp_nx;
	end

	// target delay from pan, rounded half to even
	always_comb begin
		pan_d    = PAN_W'(17'd32768 - {1'b0, pan_pos});
		pan_prod = DLY_W'(pan_d) * DLY_W'(full_delay_q);
		nd       = pan_prod[DLY_W-1:15];
		nd_rem   = pan_prod[14:0];
		nd_up    = (nd_rem > 15'd16384) || ((nd_rem == 15'd16384) && nd[0]);
		nd_r     = nd + (TGT_W+1)'(nd_up);
		nd_p     = pan_pos[PAN_W-1] ? '0 : nd_r;
		nd_c     = ({4'b0, nd_p} > DEPTH_V) ? DEPTH_V[TGT_W-1:0] : nd_p[TGT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q      <= '0;
			wrapped_q     <= 1'b0;
			cur_q         <= '0;
			tgt_q         <= '0;
			ramp_q        <= 1'b0;
			seen_q        <= 1'b0;
			full_delay_q  <= '0;
			interp_step_q <= STEP_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FULL_DELAY:  full_delay_q  <= cfg_data[FULL_W-1:0];
					CFG_INTERP_STEP: interp_step_q <= cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
			if (acc_pan && (nd_c != tgt_q)) begin
				tgt_q <= nd_c;
				if (seen_q) begin
					ramp_q <= 1'b1;
				end else begin
					cur_q <= {nd_c, {FRAC_W{1'b0}}};
				end
			end
			if (acc_smp) begin
				seen_q <= 1'b1;
				if (ramp_q) begin
					cur_q  <= cur_nx;
					ramp_q <= ramp_nx;
				end
			end
			if (we) begin
				wr_idx_q <= wr_idx_q + AW'(1);
				if (wr_idx_q == '1) begin
					wrapped_q <= 1'b1;
				end
			end
		end
	end

	pfdl_ram #(
		.WIDTH (SMP_W),
		.DEPTH (BUFFER_DEPTH)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (wr_idx_q),
		.wdata   (sample_in),
		.re      (acc_smp),
		.raddr_a (rp),
		.raddr_b (fp),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	pfdl_interp u_interp (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (acc_smp),
		.item       (item),
		.rd_a       (rd_a),
		.rd_b       (rd_b),
		.hold       (hold),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.delay_now  (delay_now),
		.ramping    (ramping)
	);

	a_settled_delay: assert property (@(posedge clk) disable iff (!arst_n)
		!ramp_q |-> (cur_q == {tgt_q, {FRAC_W{1'b0}}}))
		else $error("delay not at target while ramp is idle");

	a_ramp_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_q |-> seen_q)
		else $error("ramp active before any sample");

	a_pan_keeps_index: assert property (@(posedge clk) disable iff (!arst_n)
		acc_pan |=> $stable(wr_idx_q) && $stable(wrapped_q))
		else $error("pan beat moved the write index");

endmodule

// File: design/pfdl_ram.sv
// generic ram: one write port, two registered read ports
module pfdl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

// File: design/pfdl_interp.sv
// interpolation pipeline: read data, multiply, round, output register
module pfdl_interp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           issue,
	input  pfdl_pkg::pfdl_item_t           item,
	input  logic [pfdl_pkg::SMP_W-1:0]     rd_a,
	input  logic [pfdl_pkg::SMP_W-1:0]     rd_b,
	output logic                           hold,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [pfdl_pkg::SMP_W-1:0] sample_out,
	output logic [pfdl_pkg::DLY_W-1:0]     delay_now,
	output logic                           ramping
);

	import pfdl_pkg::*;

	localparam int PROD_W = SMP_W + 1 + FRAC_W + 1;

	logic                     s1_valid_q;
	pfdl_item_t               item_s1;
	logic                     s2_valid_q;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SMP_W-1:0]  second_s2;
	logic [DLY_W-1:0]         delay_s2;
	logic                     ramping_s2;
	logic                     out_valid_q;

	logic                     out_move;
	logic                     s2_move;
	logic signed [SMP_W-1:0]  first;
	logic signed [SMP_W-1:0]  second;
	logic signed [SMP_W:0]    diff;
	logic signed [PROD_W-1:0] rnd;
	logic signed [PROD_W-1:0] shifted;
	logic signed [SMP_W-1:0]  result;

	assign out_move = s2_valid_q && (!out_valid_q || !out_stall);
	assign s2_move  = s1_valid_q && (!s2_valid_q || out_move);
	assign hold     = s1_valid_q && !s2_move;

	always_comb begin
		first  = item_s1.b_ok ? $signed(rd_b) : '0;
		second = item_s1.use_in ? item_s1.smp : (item_s1.a_ok ? $signed(rd_a) : '0);
		diff   = {first[SMP_W-1], first} - {second[SMP_W-1], second};
	end

	assign rnd     = prod_s2 + PROD_W'(32768);
	assign shifted = rnd >>> FRAC_W;
	assign result  = second_s2 + shifted[SMP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			s1_valid_q  <= issue || (s1_valid_q && !s2_move);
			s2_valid_q  <= s2_move || (s2_valid_q && !out_move);
			out_valid_q <= out_move || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			item_s1 <= item;
		end
		if (s2_move) begin
			prod_s2    <= PROD_W'(diff) * PROD_W'($signed({1'b0, item_s1.frac}));
			second_s2  <= second;
			delay_s2   <= item_s1.delay;
			ramping_s2 <= item_s1.ramping;
		end
		if (out_move) begin
			sample_out <= result;
			delay_now  <= delay_s2;
			ramping    <= ramping_s2;
		end
	end

	assign out_valid = out_valid_q;

	a_no_issue_on_hold: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> !hold)
		else $error("beat issued while first stage is held");

	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s2_move |=> s1_valid_q)
		else $error("held first stage beat lost");

	a_s2_blocked_only_by_out: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q && !out_move |-> out_valid_q && out_stall)
		else $error("second stage stuck with output free");

endmodule

// File: tb/sv/tb_pan_fractional_delay_line.sv
// self-checking testbench for the pan-driven fractional delay line
`timescale 1ns / 100ps

module tb_pan_fractional_delay_line;
	import pfdl_pkg::*;

	localparam int DEPTH = BUFFER_DEPTH_DEF;
	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd15;

	typedef struct packed {
		logic              op;
		logic [SMP_W-1:0]  smp;
		logic [PAN_W-1:0]  pan;
	} audio_beat_t;

	typedef struct packed {
		logic [SMP_W-1:0]  smp;
		logic [DLY_W-1:0]  dly;
		logic              ramp;
	} delay_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   op = OP_SAMPLE;
	logic signed [SMP_W-1:0] sample_in = '0;
	logic [PAN_W-1:0]       pan_pos = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [SMP_W-1:0] sample_out;
	logic [DLY_W-1:0]       delay_now;
	logic                   ramping;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	audio_beat_t   beats_to_send[$];
	delay_result_t results_due[$];
	audio_beat_t   on_wire;
	delay_result_t want;

	int send_idle = 0;
	int recv_idle = 0;
	int n_taken = 0;
	int n_errors = 0;
	logic hold_out = 1'b0;
	logic [PAN_W-1:0] last_pan = '0;

	// shadow of the block's registers and delay state
	logic [FULL_W-1:0] full_delay_q = '0;
	logic [STEP_W-1:0] ramp_step_q = STEP_RESET;
	logic [SMP_W-1:0]  store_q [DEPTH];
	logic [IDX_W-1:0]  wr_q = '0;
	logic [31:0]       cur_dly = '0;
	logic [TGT_W-1:0]  tgt_q = '0;
	logic              ramp_q = 1'b0;
	logic              seen_q = 1'b0;

	pan_fractional_delay_line u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.sample_in    (sample_in),
		.pan_pos      (pan_pos),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_out   (sample_out),
		.delay_now    (delay_now),
		.ramping      (ramping),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		n_errors++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	// advance the delay line by one beat and queue the result it gives
	task automatic step_delay_line(input audio_beat_t b);
		logic [31:0] tgt_fx;
		logic [31:0] n;
		logic [31:0] nd;
		logic [IDX_W-1:0] rp;
		logic [IDX_W-1:0] fp;
		logic [SMP_W-1:0] res;
		logic bypass;
		longint fr;
		longint first;
		longint second;
		longint acc;
		if (b.op == OP_PAN) begin
			nd = '0;
			if (b.pan < 16'd32768) begin
				n = (32'd32768 - 32'(b.pan)) * 32'(full_delay_q);
				nd = n >> 15;
				if (n[14:0] > 15'd16384 || (n[14:0] == 15'd16384 && nd[0]))
					nd++;
			end
			if (nd > DEPTH)
				nd = DEPTH;
			if (nd != 32'(tgt_q)) begin
				if (seen_q)
					ramp_q = 1'b1;
				else
					cur_dly = nd << 16;
				tgt_q = nd[TGT_W-1:0];
			end
		end else begin
			seen_q = 1'b1;
			bypass = !ramp_q && tgt_q == '0;
			res = b.smp;
			tgt_fx = 32'(tgt_q) << 16;
			if (ramp_q) begin
				if (cur_dly >= tgt_fx) begin
					if (cur_dly <= tgt_fx + ramp_step_q) begin
						cur_dly = tgt_fx;
						ramp_q = 1'b0;
					end else begin
						cur_dly = cur_dly - ramp_step_q;
					end
				end
				rp = wr_q - cur_dly[16 +: IDX_W];
				fp = rp - 1'b1;
				fr = longint'(cur_dly[15:0]);
				first = longint'($signed(store_q[fp]));
				if (cur_dly[31:16] == '0)
					second = longint'($signed(b.smp));
				else
					second = longint'($signed(store_q[rp]));
				acc = first * fr + second * (64'sd65536 - fr);
				acc = (acc + 64'sd32768) >>> 16;
				res = acc[SMP_W-1:0];
				if (cur_dly < tgt_fx) begin
					cur_dly = cur_dly + ramp_step_q;
					if (cur_dly >= tgt_fx) begin
						cur_dly = tgt_fx;
						ramp_q = 1'b0;
					end
				end
			end else if (!bypass) begin
				res = store_q[wr_q - tgt_q[IDX_W-1:0]];
			end
			if (!bypass) begin
				store_q[wr_q] = b.smp;
				wr_q = wr_q + 1'b1;
			end
			results_due.push_back('{smp: res, dly: cur_dly[DLY_W-1:0], ramp: ramp_q});
		end
	endtask

	// input side
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				step_delay_line(on_wire);
				n_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle) begin
					on_wire = beats_to_send.pop_front();
					in_valid <= 1'b1;
					op <= on_wire.op;
					sample_in <= on_wire.smp;
					pan_pos <= on_wire.pan;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					flag_error("result beat with nothing expected");
				end else begin
					want = results_due.pop_front();
					if (sample_out !== want.smp)
						flag_error($sformatf("sample_out %h, want %h", sample_out, want.smp));
					if (delay_now !== want.dly)
						flag_error($sformatf("delay_now %h, want %h", delay_now, want.dly));
					if (ramping !== want.ramp)
						flag_error($sformatf("ramping %b, want %b", ramping, want.ramp));
				end
			end
			out_stall <= hold_out || ($urandom_range(99) < recv_idle);
		end
	end

	// long hold-off on the output so the block backs up into its input
	initial begin
		while (n_taken < 400 || beats_to_send.size() < 40)
			@(posedge clk);
		hold_out <= 1'b1;
		repeat (200) @(posedge clk);
		hold_out <= 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_FULL_DELAY)
			full_delay_q = val[FULL_W-1:0];
		else if (idx == CFG_INTERP_STEP)
			ramp_step_q = val;
	endtask

	task automatic settle();
		while (beats_to_send.size() != 0 || in_valid || results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic push_sample(input logic [SMP_W-1:0] s);
		beats_to_send.push_back('{op: OP_SAMPLE, smp: s, pan: PAN_W'($urandom())});
	endtask

	task automatic push_pan(input logic [PAN_W-1:0] p);
		beats_to_send.push_back('{op: OP_PAN, smp: SMP_W'($urandom()), pan: p});
	endtask

	// pan moves followed by runs of samples, with pans biased to ties and near neighbours
	task automatic queue_random_run(input int count);
		logic [PAN_W-1:0] p;
		logic [SMP_W-1:0] s;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(7) == 0) begin
				case ($urandom_range(7))
					0: p = '0;
					1: p = '1;
					2: p = 16'd32768;
					3: p = 16'(8192 * $urandom_range(1, 3));
					4: p = last_pan + 16'($urandom_range(128)) - 16'd64;
					5: p = 16'($urandom_range(32767));
					default: p = PAN_W'($urandom());
				endcase
				last_pan = p;
				push_pan(p);
			end else begin
				case ($urandom_range(9))
					0: s = 24'h7FFFFF;
					1: s = 24'h800000;
					default: s = SMP_W'($urandom());
				endcase
				push_sample(s);
			end
		end
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] full, input logic [CFG_DATA_W-1:0] step,
			input int s_idle, input int r_idle);
		settle();
		write_reg(CFG_FULL_DELAY, full);
		write_reg(CFG_INTERP_STEP, step);
		send_idle = s_idle;
		recv_idle = r_idle;
		queue_random_run(170);
	endtask

	initial begin
		foreach (store_q[i])
			store_q[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_idle = 25;
		recv_idle = 47;

		// pans before the first sample jump straight to the target
		write_reg(CFG_FULL_DELAY, 16'd4);
		write_reg(CFG_INTERP_STEP, 16'd32768);
		push_pan(16'd0);
		push_pan(16'hFFFF);
		push_pan(16'd16384);
		push_sample(24'h7FFFFF);
		push_sample(24'h800000);
		push_sample(24'h000000);
		push_sample(24'h000001);
		// ramp down to zero, last steps interpolate against the live input
		push_pan(16'd32768);
		push_sample(24'hFFFFFF);
		push_sample(24'h123456);
		push_sample(24'h654321);
		push_sample(24'hABCDEF);
		// bypass with zero delay
		push_sample(24'h7FFFFF);
		push_sample(24'h800000);
		// ramp up from zero
		push_pan(16'd24576);
		push_sample(24'h400000);
		push_sample(24'hC00000);
		push_sample(24'h0F0F0F);
		settle();
		// rounding tie goes to even
		write_reg(CFG_FULL_DELAY, 16'd3);
		push_pan(16'd16384);
		push_sample(24'h555555);
		push_sample(24'hAAAAAA);

		run_phase(16'd2048, 16'd65535, 25, 47);
		run_phase(16'd37, 16'd20000, 25, 47);
		settle();
		write_reg(CFG_SPARE, 16'hFFFF);
		run_phase(16'hFFFF, 16'd65535, 25, 47);
		run_phase(16'd5, 16'd0, 47, 25);
		run_phase(16'd1, 16'd1, 47, 25);
		run_phase(16'd100, 16'd4096, 47, 25);
		run_phase(16'd12, STEP_RESET, 0, 0);
		run_phase(16'd0, 16'd40000, 0, 0);
		run_phase(16'd2048, 16'd65535, 0, 0);
		settle();

		if (n_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
